// ===== src/skt_pkg.sv =====
// shared types, constants and command/status codes of the sorted key table
// no dependencies
package skt_pkg;

   localparam int SKT_TABLE_DEPTH = 64;
   localparam logic [31:0] SKT_LEVEL_SCALE_RESET = 32'd65535;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_APPLY  = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO_KEY  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DUP       = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] level;
      logic [31:0] degrade;
      logic [31:0] recover;
      logic [63:0] last_time;
   } record_type;

   typedef struct packed {
      logic [2:0] status;
      logic       found;
      logic [5:0] slot;
      record_type rec;
   } result_type;

endpackage

// ===== src/skt_ifs.sv =====
// request and response channel interfaces of the sorted key table
// depends on nothing; payload fields are plain vectors
interface skt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [63:0]        key;
   logic [31:0]        init_level;
   logic [31:0]        degrade_rate;
   logic [31:0]        recover_rate;
   logic signed [31:0] delta;
   logic [63:0]        act_time;

   modport source (output valid, cmd, key, init_level, degrade_rate, recover_rate, delta,
                   act_time, input ready);
   modport sink (input valid, cmd, key, init_level, degrade_rate, recover_rate, delta,
                 act_time, output ready);
endinterface

interface skt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        found;
   logic [5:0]  slot;
   logic [31:0] level_out;
   logic [31:0] degrade_out;
   logic [31:0] recover_out;
   logic [63:0] last_time_out;

   modport source (output valid, status, found, slot, level_out, degrade_out, recover_out,
                   last_time_out, input ready);
   modport sink (input valid, status, found, slot, level_out, degrade_out, recover_out,
                 last_time_out, output ready);
endinterface

// ===== src/skt_store.sv =====
// record memory of the sorted key table: one write port, one registered read port
// depends on skt_pkg
module skt_store
   import skt_pkg::*;
#(
   parameter int TABLE_DEPTH = SKT_TABLE_DEPTH,
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output record_type    rd_data,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  record_type    wr_data
);

   record_type mem [TABLE_DEPTH];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sorted_key_table_saturating_level.sv =====
// Sorted key table holding up to TABLE_DEPTH records in ascending key order, with a
// saturating level per record. One transaction is handled at a time. A command reads
// the record memory one entry per cycle from slot 0 until it meets its key, a larger
// one or the end of the table. An insert that adds a record then moves every later
// entry up by one slot, reading and then writing each, and writes the new record into
// the freed slot. A zero key or a full table on insert is answered without a scan.
// The next request is taken while the previous response still waits in the output
// register.
// depends on skt_pkg, skt_ifs and skt_store
module sorted_key_table_saturating_level
   import skt_pkg::*;
#(
   parameter int TABLE_DEPTH = SKT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   skt_req_if.sink     req_chan,
   skt_rsp_if.source   rsp_chan
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_SHIFT_RD = 3'd2;
   localparam logic [2:0] S_SHIFT_WR = 3'd3;
   localparam logic [2:0] S_DONE     = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [31:0]        scale_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [63:0]        key_ff, key_in;
   logic [31:0]        lvl_ff, lvl_in;
   logic [31:0]        drate_ff, drate_in;
   logic [31:0]        rrate_ff, rrate_in;
   logic signed [31:0] delta_ff, delta_in;
   logic [63:0]        time_ff, time_in;
   result_type         res_ff, res_in;
   result_type         out_ff;
   logic               out_valid_ff;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   record_type    rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   record_type    wr_data;

   logic               accept;
   logic               out_free;
   logic [CW-1:0]      idx_next;
   logic [CW-1:0]      idx_prev;
   logic signed [33:0] sum;
   logic [31:0]        new_level;
   record_type         new_rec;

   skt_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign idx_next = idx_ff + CW'(1);
   assign idx_prev = idx_ff - CW'(1);

   // saturating apply arithmetic on the record just read
   always_comb begin
      sum = signed'({2'b00, rd_data.level}) + signed'({{2{delta_ff[31]}}, delta_ff});
      if (sum[33]) begin
         new_level = '0;
      end else if (sum[32:0] > {1'b0, scale_ff}) begin
         new_level = scale_ff;
      end else begin
         new_level = sum[31:0];
      end
   end

   // record built by a successful insert
   always_comb begin
      new_rec.key       = key_ff;
      new_rec.level     = (lvl_ff > scale_ff) ? scale_ff : lvl_ff;
      new_rec.degrade   = drate_ff;
      new_rec.recover   = rrate_ff;
      new_rec.last_time = '0;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      lvl_in   = lvl_ff;
      drate_in = drate_ff;
      rrate_in = rrate_ff;
      delta_in = delta_ff;
      time_in  = time_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = new_rec;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_chan.cmd;
               key_in   = req_chan.key;
               lvl_in   = req_chan.init_level;
               drate_in = req_chan.degrade_rate;
               rrate_in = req_chan.recover_rate;
               delta_in = req_chan.delta;
               time_in  = req_chan.act_time;
               res_in   = '0;
               idx_in   = '0;
               pos_in   = '0;
               if (req_chan.cmd == CMD_INSERT && req_chan.key == '0) begin
                  res_in.status = ST_ZERO_KEY;
                  state_in = S_DONE;
               end else if (req_chan.cmd == CMD_INSERT && count_ff >= DEPTH_C) begin
                  res_in.status = ST_FULL;
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  if (req_chan.cmd == CMD_INSERT) begin
                     state_in = S_SHIFT_RD;
                  end else begin
                     res_in.status = ST_NOT_FOUND;
                     state_in = S_DONE;
                  end
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (rd_data.key == key_ff) begin
               res_in.found = 1'b1;
               res_in.slot  = 6'(idx_ff);
               res_in.rec   = rd_data;
               if (cmd_ff == CMD_INSERT) begin
                  res_in.status = ST_DUP;
               end else begin
                  res_in.status = ST_OK;
                  if (cmd_ff == CMD_APPLY) begin
                     wr_en                  = 1'b1;
                     wr_addr                = idx_ff[IW-1:0];
                     wr_data                = rd_data;
                     wr_data.level          = new_level;
                     wr_data.last_time      = time_ff;
                     res_in.rec.level       = new_level;
                     res_in.rec.last_time   = time_ff;
                  end
               end
               state_in = S_DONE;
            end else if (rd_data.key > key_ff || idx_next == count_ff) begin
               pos_in = (rd_data.key > key_ff) ? idx_ff : idx_next;
               if (cmd_ff == CMD_INSERT) begin
                  idx_in   = count_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  res_in.status = ST_NOT_FOUND;
                  res_in.slot   = (rd_data.key > key_ff) ? 6'(idx_ff) : 6'(idx_next);
                  state_in      = S_DONE;
               end
            end else begin
               idx_in  = idx_next;
               rd_en   = 1'b1;
               rd_addr = idx_next[IW-1:0];
            end
         end

         S_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               wr_en         = 1'b1;
               wr_addr       = pos_ff[IW-1:0];
               wr_data       = new_rec;
               count_in      = count_ff + CW'(1);
               res_in.status = ST_OK;
               res_in.found  = 1'b0;
               res_in.slot   = 6'(pos_ff);
               res_in.rec    = new_rec;
               state_in      = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_prev[IW-1:0];
               state_in = S_SHIFT_WR;
            end
         end

         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IW-1:0];
            wr_data  = rd_data;
            idx_in   = idx_prev;
            state_in = S_SHIFT_RD;
         end

         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scale_ff     <= SKT_LEVEL_SCALE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
         if (state_ff == S_DONE && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      lvl_ff   <= lvl_in;
      drate_ff <= drate_in;
      rrate_ff <= rrate_in;
      delta_ff <= delta_in;
      time_ff  <= time_in;
      res_ff   <= res_in;
      if (state_ff == S_DONE && out_free) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_ff.status;
   assign rsp_chan.found         = out_ff.found;
   assign rsp_chan.slot          = out_ff.slot;
   assign rsp_chan.level_out     = out_ff.rec.level;
   assign rsp_chan.degrade_out   = out_ff.rec.degrade;
   assign rsp_chan.recover_out   = out_ff.rec.recover;
   assign rsp_chan.last_time_out = out_ff.rec.last_time;

endmodule
